// ----- src/scsi_pseudo_dma_byte_packer_unit_macros.svh -----
// Assertion macros shared by the byte packer checker.
`ifndef SCSI_PSEUDO_DMA_BYTE_PACKER_UNIT_MACROS_SVH
`define SCSI_PSEUDO_DMA_BYTE_PACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPDBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte packer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPDBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte packer check failed");

`endif

// ----- src/spdbp_pkg.sv -----
// Types and constants for the SCSI pseudo-DMA byte packer.
`timescale 1ns / 1ps
package spdbp_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 48;

  // Event kinds carried on the input channel.
  typedef enum logic [1:0] {
    KIND_DRQ = 2'd0,
    KIND_IRQ = 2'd1,
    KIND_RD  = 2'd2,
    KIND_WR  = 2'd3
  } kind_t;

  // Transfer phase: read with bytes taken, word ready, write with bytes left.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_RD1  = 3'd1,
    PH_RD2  = 3'd2,
    PH_RD3  = 3'd3,
    PH_RD4  = 3'd4,
    PH_WR3  = 3'd5,
    PH_WR2  = 3'd6,
    PH_WR1  = 3'd7
  } phase_t;

  // One result transaction.
  typedef struct packed {
    logic             release_wait;
    logic [ByteW-1:0] write_byte;
    logic             write_strobe;
    logic             byte_taken;
    logic [WordW-1:0] read_data;
  } result_t;

endpackage

// ----- src/scsi_pseudo_dma_byte_packer_unit.sv -----
// Top level of the SCSI pseudo-DMA byte packer.
//
// Input channel in_*: one transaction per event. in_tuser carries the event
// kind (DRQ line, IRQ line, CPU read, CPU write); in_tdata carries the new
// line level, the byte the controller presents and the CPU write word.
// Output channel out_*: exactly one result transaction per input event, in
// order: read word, byte-taken flag, write strobe and byte, wait release.
// Latency: the result is valid in the cycle after the input is accepted.
// Throughput: one event per cycle unless the receiver stalls; state is updated
// by the step logic in the same cycle the event is accepted, and the result
// lands in one output register.
// Backpressure: in_tready is high while the output register is empty or is
// being drained, so a stalled receiver holds the result and stops input after
// one event.
// Reset (rst_n low, synchronous): phase goes to idle, the word buffer and the
// stored DRQ and IRQ levels clear, and the output register empties.
`timescale 1ns / 1ps
module scsi_pseudo_dma_byte_packer_unit
  import spdbp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [0] line_level, [8:1] scsi_byte, [40:9] cpu_data
  input  logic [1:0]          in_tuser,   // [1:0] kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata   // [31:0] read_data, [32] scsi_byte_taken,
                                          // [33] scsi_write_strobe,
                                          // [41:34] scsi_write_byte,
                                          // [42] cpu_ready_release
);

  phase_t           phase_r, phase_nxt;
  logic [WordW-1:0] word_buf_r, word_buf_nxt;
  logic             drq_r, drq_nxt;
  logic             irq_r, irq_nxt;
  result_t          result_nxt, result_r;
  logic             out_valid_r;
  logic             in_xact;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xact   = in_tvalid && in_tready;

  spdbp_step u_step (
    .kind          (kind_t'(in_tuser)),
    .line_level    (in_tdata[0]),
    .scsi_byte     (in_tdata[8:1]),
    .cpu_data      (in_tdata[40:9]),
    .phase         (phase_r),
    .word_buf      (word_buf_r),
    .drq_level     (drq_r),
    .irq_level     (irq_r),
    .phase_nxt     (phase_nxt),
    .word_buf_nxt  (word_buf_nxt),
    .drq_level_nxt (drq_nxt),
    .irq_level_nxt (irq_nxt),
    .result        (result_nxt)
  );

  // Transfer state, updated on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      word_buf_r <= '0;
      drq_r      <= 1'b0;
      irq_r      <= 1'b0;
    end else if (in_xact) begin
      phase_r    <= phase_nxt;
      word_buf_r <= word_buf_nxt;
      drq_r      <= drq_nxt;
      irq_r      <= irq_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xact) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_xact) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-$bits(result_t)){1'b0}}, result_r};

endmodule

// ----- src/spdbp_step.sv -----
// Next-state and result logic for one event of the byte packer.
`timescale 1ns / 1ps
module spdbp_step
  import spdbp_pkg::*;
(
  input  kind_t            kind,
  input  logic             line_level,
  input  logic [ByteW-1:0] scsi_byte,
  input  logic [WordW-1:0] cpu_data,
  input  phase_t           phase,
  input  logic [WordW-1:0] word_buf,
  input  logic             drq_level,
  input  logic             irq_level,
  output phase_t           phase_nxt,
  output logic [WordW-1:0] word_buf_nxt,
  output logic             drq_level_nxt,
  output logic             irq_level_nxt,
  output result_t          result
);

  // Byte for the current write phase: WR3 sends byte 1, WR2 byte 2, WR1 byte 3
  logic [ByteW-1:0] wr_byte;
  always_comb begin
    case (phase)
      PH_WR3:  wr_byte = word_buf[15:8];
      PH_WR2:  wr_byte = word_buf[23:16];
      PH_WR1:  wr_byte = word_buf[31:24];
      default: wr_byte = '0;
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt     = phase;
    word_buf_nxt  = word_buf;
    drq_level_nxt = drq_level;
    irq_level_nxt = irq_level;
    case (kind)
      KIND_DRQ: begin
        drq_level_nxt = line_level;
        if (line_level) begin
          case (phase)
            PH_RD1: begin
              word_buf_nxt[15:8] = word_buf[15:8] | scsi_byte;
              phase_nxt = PH_RD2;
            end
            PH_RD2: begin
              word_buf_nxt[23:16] = word_buf[23:16] | scsi_byte;
              phase_nxt = PH_RD3;
            end
            PH_RD3: begin
              word_buf_nxt[31:24] = word_buf[31:24] | scsi_byte;
              phase_nxt = PH_RD4;
            end
            PH_WR3:  phase_nxt = PH_WR2;
            PH_WR2:  phase_nxt = PH_WR1;
            PH_WR1:  phase_nxt = PH_IDLE;
            default: phase_nxt = phase;
          endcase
        end
      end
      KIND_IRQ: begin
        irq_level_nxt = line_level;
        if (line_level) begin
          case (phase)
            PH_RD1, PH_RD2, PH_RD3: phase_nxt = PH_RD4;
            PH_WR3, PH_WR2, PH_WR1: phase_nxt = PH_IDLE;
            default:                phase_nxt = phase;
          endcase
        end
      end
      KIND_RD: begin
        if (phase == PH_IDLE && drq_level && !irq_level) begin
          word_buf_nxt = {{(WordW-ByteW){1'b0}}, scsi_byte};
          phase_nxt    = PH_RD1;
        end else if (phase == PH_RD4) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        if (phase == PH_IDLE && drq_level) begin
          word_buf_nxt = cpu_data;
          phase_nxt    = PH_WR3;
        end
      end
    endcase
  end

  // Result
  always_comb begin
    result = '0;
    case (kind)
      KIND_DRQ: begin
        if (line_level) begin
          case (phase)
            PH_RD1, PH_RD2, PH_RD3: result.byte_taken = 1'b1;
            PH_WR3, PH_WR2, PH_WR1: begin
              result.write_strobe = 1'b1;
              result.write_byte   = wr_byte;
            end
            default: result = '0;
          endcase
        end
      end
      KIND_IRQ: result = '0;
      KIND_RD: begin
        case (phase)
          PH_IDLE: begin
            if (drq_level && !irq_level) begin
              result.byte_taken   = 1'b1;
              result.release_wait = 1'b1;
            end
          end
          PH_RD1, PH_RD2, PH_RD3: result.release_wait = 1'b1;
          PH_RD4:  result.read_data = word_buf;
          default: result = '0;
        endcase
      end
      default: begin
        if (phase == PH_IDLE) begin
          if (drq_level) begin
            result.write_strobe = 1'b1;
            result.write_byte   = cpu_data[ByteW-1:0];
          end
        end else begin
          result.release_wait = 1'b1;
        end
      end
    endcase
  end

endmodule

// ----- src/spdbp_checker.sv -----
// Port-level checker for the byte packer, bound to the top level.
`timescale 1ns / 1ps
`include "scsi_pseudo_dma_byte_packer_unit_macros.svh"
module spdbp_checker
  import spdbp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // A stalled result stays valid and unchanged
  `SPDBP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Every accepted event yields a result in the next cycle
  `SPDBP_ASSERT_NEXT(a_one_result, in_tvalid && in_tready, out_tvalid)

  // No input is taken while a result waits and the receiver stalls
  `SPDBP_ASSERT_NOW(a_no_overrun, out_tvalid && !out_tready, !in_tready)

  // A returned word comes with no byte traffic and no wait release
  `SPDBP_ASSERT_NOW(a_word_alone, out_tvalid && (out_tdata[31:0] != 32'd0),
    out_tdata[42:32] == 11'd0)

  // Taking a byte and strobing a byte never happen together
  `SPDBP_ASSERT_NOW(a_dir_excl, out_tvalid, !(out_tdata[32] && out_tdata[33]))

endmodule

bind scsi_pseudo_dma_byte_packer_unit spdbp_checker u_spdbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
